### rtl/npd_pkg.sv
// Shared constants for the packet deframer: register indexes, reset values,
// CRC-16/CCITT parameters, trailer bytes and frame status codes.
// No dependencies.
`default_nettype none

package npd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = BYTE_W;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WANTED_ID   = 2'd1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h81;
    localparam logic [BYTE_W-1:0] ID_RESET     = 8'h56;

    // CRC-16/XMODEM: poly 0x1021, init 0, no reflection, no final xor
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    localparam logic [BYTE_W-1:0] TRAIL_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] TRAIL_LF = 8'h0A;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_CRC_ERR  = 2'd1,
        STATUS_TRAILER  = 2'd2,
        STATUS_WRONG_ID = 2'd3
    } frame_status_t;

    // Output transaction packing
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 1;

endpackage

`default_nettype wire

### rtl/npd_crc16_byte.sv
// Bytewise CRC-16/CCITT update, MSB first, eight shift-xor steps.
// Depends on npd_pkg for the polynomial and widths.
`default_nettype none

module npd_crc16_byte (
    input  wire logic [npd_pkg::CRC_W-1:0]  crc_in,
    input  wire logic [npd_pkg::BYTE_W-1:0] data_in,
    output logic      [npd_pkg::CRC_W-1:0]  crc_out
);
    import npd_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

### rtl/nav_packet_deframer_crc16_core.sv
// Serial packet deframer with CRC-16/CCITT check: top level.
// Throughput: one byte per cycle while the result stream is not stalled; the per-byte path is the frame
//   state decode plus one bytewise CRC update (eight shift-xor steps).
// Output: a result transaction is registered and valid in the cycle after its byte is accepted.
// Reset (aresetn low, synchronous): hunt for the first header byte, clear
//   frame state, empty the output register, restore both config registers.
// Depends on npd_pkg and npd_crc16_byte.
`default_nettype none

module nav_packet_deframer_crc16_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [npd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [npd_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [npd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte

    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [17:16] frame_status,
    // [25:18] frame_length, [31:26] zero
    output logic [npd_pkg::TDATA_W-1:0]          m_tdata,
    output logic [npd_pkg::TUSER_W-1:0]          m_tuser,   // [0] payload_valid
    output logic                                 m_tlast    // frame_end
);
    import npd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT1   = 4'd0,
        PH_HUNT2   = 4'd1,
        PH_ADDR    = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN     = 4'd4,
        PH_SPARE   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRCH    = 4'd7,
        PH_CRCL    = 4'd8,
        PH_CR      = 4'd9,
        PH_LF      = 4'd10
    } phase_t;

    // Configuration registers
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] wanted_id_reg;

    // Frame state
    phase_t            phase_reg,    phase_next;
    logic [CRC_W-1:0]  crc_acc_reg,  crc_acc_next;
    logic [BYTE_W-1:0] length_reg,   length_next;
    logic [BYTE_W-1:0] count_reg,    count_next;
    logic [CRC_W-1:0]  rx_crc_reg,   rx_crc_next;
    logic              id_match_reg, id_match_next;
    logic              trl_bad_reg,  trl_bad_next;

    // Output register
    logic              m_valid_reg;
    logic              pv_reg,       pv_next;
    logic [BYTE_W-1:0] pb_reg,       pb_next;
    logic [BYTE_W-1:0] pi_reg,       pi_next;
    logic              fe_reg,       fe_next;
    frame_status_t     fs_reg,       fs_next;
    logic [BYTE_W-1:0] fl_reg,       fl_next;

    logic              s_accept;
    logic [BYTE_W-1:0] rx_byte;
    logic [CRC_W-1:0]  crc_seed;
    logic [CRC_W-1:0]  crc_upd;
    logic [BYTE_W-1:0] count_inc;
    logic              lf_bad;

    // Accept a new byte whenever the output register is empty or draining
    // this cycle; the frame state never stalls the input on its own.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign rx_byte  = s_tdata;

    // The address byte restarts the CRC from its initial value.
    assign crc_seed  = (phase_reg == PH_ADDR) ? CRC_INIT : crc_acc_reg;
    assign count_inc = count_reg + 8'd1;
    assign lf_bad    = trl_bad_reg || (rx_byte != TRAIL_LF);

    npd_crc16_byte u_crc (
        .crc_in  (crc_seed),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    // Next frame state and result fields for the byte at the input.
    always_comb begin
        phase_next    = phase_reg;
        crc_acc_next  = crc_acc_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        rx_crc_next   = rx_crc_reg;
        id_match_next = id_match_reg;
        trl_bad_next  = trl_bad_reg;

        pv_next = 1'b0;
        pb_next = '0;
        pi_next = '0;
        fe_next = 1'b0;
        fs_next = STATUS_GOOD;
        fl_next = '0;

        unique case (phase_reg)
            PH_HUNT1: begin
                if (rx_byte == header_reg) begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // Broken sync: fall back to hunting the first header byte
                phase_next = (rx_byte == header_reg) ? PH_ADDR : PH_HUNT1;
            end
            PH_ADDR: begin
                crc_acc_next = crc_upd;
                trl_bad_next = 1'b0;
                rx_crc_next  = '0;
                count_next   = '0;
                phase_next   = PH_ID;
            end
            PH_ID: begin
                crc_acc_next  = crc_upd;
                id_match_next = (rx_byte == wanted_id_reg);
                phase_next    = PH_LEN;
            end
            PH_LEN: begin
                crc_acc_next = crc_upd;
                length_next  = rx_byte;
                phase_next   = PH_SPARE;
            end
            PH_SPARE: begin
                crc_acc_next = crc_upd;
                count_next   = '0;
                // Empty payload goes straight to the CRC bytes
                phase_next   = (length_reg == '0) ? PH_CRCH : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc_next = crc_upd;
                if (id_match_reg) begin
                    pv_next = 1'b1;
                    pb_next = rx_byte;
                    pi_next = count_reg;
                end
                count_next = count_inc;
                if (count_inc == length_reg) begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH: begin
                rx_crc_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next  = PH_CRCL;
            end
            PH_CRCL: begin
                rx_crc_next = rx_crc_reg | {{BYTE_W{1'b0}}, rx_byte};
                phase_next  = PH_CR;
            end
            PH_CR: begin
                trl_bad_next = (rx_byte != TRAIL_CR);
                phase_next   = PH_LF;
            end
            PH_LF: begin
                // Wrong id outranks trailer error, which outranks CRC error
                fe_next = 1'b1;
                fl_next = length_reg;
                priority if (!id_match_reg) begin
                    fs_next = STATUS_WRONG_ID;
                end else if (lf_bad) begin
                    fs_next = STATUS_TRAILER;
                end else if (rx_crc_reg != crc_acc_reg) begin
                    fs_next = STATUS_CRC_ERR;
                end else begin
                    fs_next = STATUS_GOOD;
                end
                phase_next = PH_HUNT1;
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // State, config and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg    <= HEADER_RESET;
            wanted_id_reg <= ID_RESET;
            phase_reg     <= PH_HUNT1;
            crc_acc_reg   <= CRC_INIT;
            length_reg    <= '0;
            count_reg     <= '0;
            rx_crc_reg    <= '0;
            id_match_reg  <= 1'b0;
            trl_bad_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Config writes; indexes beyond the register list are dropped
            if (cfg_we) begin
                if (cfg_addr == REG_HEADER_BYTE) begin
                    header_reg <= cfg_wdata;
                end else if (cfg_addr == REG_WANTED_ID) begin
                    wanted_id_reg <= cfg_wdata;
                end
            end

            // Advance the frame state once per accepted transaction
            if (s_accept) begin
                phase_reg    <= phase_next;
                crc_acc_reg  <= crc_acc_next;
                length_reg   <= length_next;
                count_reg    <= count_next;
                rx_crc_reg   <= rx_crc_next;
                id_match_reg <= id_match_next;
                trl_bad_reg  <= trl_bad_next;
            end

            // Load on accept, otherwise drop valid once the result is taken
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // Result payload holds while stalled; no reset needed
        if (s_accept) begin
            pv_reg <= pv_next;
            pb_reg <= pb_next;
            pi_reg <= pi_next;
            fe_reg <= fe_next;
            fs_reg <= fs_next;
            fl_reg <= fl_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - 4*BYTE_W + 6){1'b0}}, fl_reg, fs_reg, pi_reg, pb_reg};
    assign m_tuser  = pv_reg;
    assign m_tlast  = fe_reg;

endmodule

`default_nettype wire
